### rtl/core/isre_pkg.sv
// ----------------------------------------------------------------------------
// isre_pkg
// Shared types and constants of the scanline run encoder: packet kinds,
// the encoded write word and the batch of writes one input byte produces.
// ----------------------------------------------------------------------------
package isre_pkg;

	localparam int unsigned MAX_WR = 5;
	localparam int unsigned CNT_W  = $clog2(MAX_WR + 1);

	localparam logic [6:0] RUN_MAX    = 7'd127;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;
	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] LIT_HDR    = 8'h80;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_SOLID = 2'd1,
		KIND_LIT   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [13:0] pos;
		logic        done;
		logic [14:0] len;
	} wr_t;

	typedef struct packed {
		logic [CNT_W-1:0]     count;
		wr_t  [MAX_WR-1:0]    wr;
	} batch_t;

endpackage

### rtl/core/isre_in_if.sv
// ----------------------------------------------------------------------------
// isre_in_if
// Input channel: one scanline byte per word, with end-of-line mark.
// ----------------------------------------------------------------------------
interface isre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, output in_byte, output end_of_line, input ready);
	modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

### rtl/core/isre_out_if.sv
// ----------------------------------------------------------------------------
// isre_out_if
// Output channel: one write into the encoded line buffer per word.
// ----------------------------------------------------------------------------
interface isre_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [13:0] out_pos;
	logic        line_done;
	logic [14:0] line_length;

	modport source (output valid, output out_byte, output out_pos, output line_done,
		output line_length, input ready);
	modport sink   (input valid, input out_byte, input out_pos, input line_done,
		input line_length, output ready);
endinterface

### rtl/core/isre_encoder.sv
// ----------------------------------------------------------------------------
// isre_encoder
// Packet state of the current line and the logic that turns one byte into
// its batch of buffer writes.
// ----------------------------------------------------------------------------
module isre_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data,
	input  logic                eol,
	output isre_pkg::batch_t    batch
);

	isre_pkg::kind_t kind_q, kind_d;
	logic            ones_q, ones_d;
	logic [6:0]      cnt_q, cnt_d;
	logic [13:0]     pstart_q, pstart_d;
	logic [14:0]     wpos_q, wpos_d;

	function automatic isre_pkg::wr_t mk_wr(input logic [7:0] b, input logic [13:0] p);
		isre_pkg::wr_t w;
		w.data = b;
		w.pos  = p;
		w.done = 1'b0;
		w.len  = '0;
		return w;
	endfunction

	always_comb begin
		logic                       solid;
		logic                       cont;
		logic [isre_pkg::CNT_W-1:0] n;
		logic [isre_pkg::CNT_W-1:0] last;
		solid    = (data == isre_pkg::BYTE_ZEROS) || (data == isre_pkg::BYTE_ONES);
		kind_d   = kind_q;
		ones_d   = ones_q;
		cnt_d    = cnt_q;
		pstart_d = pstart_q;
		wpos_d   = wpos_q;
		batch    = '0;
		n        = '0;
		last     = '0;
		cont = ((kind_q == isre_pkg::KIND_SOLID)
				&& (data == (ones_q ? isre_pkg::BYTE_ONES : isre_pkg::BYTE_ZEROS))
				&& (cnt_q < isre_pkg::RUN_MAX))
			|| ((kind_q == isre_pkg::KIND_LIT) && !solid && (cnt_q < isre_pkg::RUN_MAX));

		if (cont) begin
			if (kind_q == isre_pkg::KIND_LIT) begin
				batch.wr[n] = mk_wr(data, wpos_q[13:0]);
				n = n + 1'b1;
				wpos_d = wpos_q + 15'd1;
			end
			cnt_d = cnt_q + 7'd1;
		end else begin
			if (kind_q == isre_pkg::KIND_SOLID) begin
				batch.wr[n] = mk_wr({ones_q, cnt_q}, pstart_q);
				n = n + 1'b1;
			end else if (kind_q == isre_pkg::KIND_LIT) begin
				batch.wr[n] = mk_wr(isre_pkg::LIT_HDR, pstart_q);
				n = n + 1'b1;
				batch.wr[n] = mk_wr({1'b0, cnt_q}, pstart_q + 14'd1);
				n = n + 1'b1;
			end
			pstart_d = wpos_q[13:0];
			cnt_d    = 7'd1;
			if (solid) begin
				kind_d = isre_pkg::KIND_SOLID;
				ones_d = (data == isre_pkg::BYTE_ONES);
				wpos_d = wpos_q + 15'd1;
			end else begin
				kind_d = isre_pkg::KIND_LIT;
				batch.wr[n] = mk_wr(data, 14'(wpos_q + 15'd2));
				n = n + 1'b1;
				wpos_d = wpos_q + 15'd3;
			end
		end

		if (eol) begin
			if (kind_d == isre_pkg::KIND_SOLID) begin
				batch.wr[n] = mk_wr({ones_d, cnt_d}, pstart_d);
				n = n + 1'b1;
			end else begin
				batch.wr[n] = mk_wr(isre_pkg::LIT_HDR, pstart_d);
				n = n + 1'b1;
				batch.wr[n] = mk_wr({1'b0, cnt_d}, pstart_d + 14'd1);
				n = n + 1'b1;
			end
			last = n - 1'b1;
			batch.wr[last].done = 1'b1;
			batch.wr[last].len  = wpos_d;
			kind_d   = isre_pkg::KIND_NONE;
			ones_d   = 1'b0;
			cnt_d    = '0;
			pstart_d = '0;
			wpos_d   = '0;
		end
		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= isre_pkg::KIND_NONE;
			ones_q   <= 1'b0;
			cnt_q    <= '0;
			pstart_q <= '0;
			wpos_q   <= '0;
		end else if (advance) begin
			kind_q   <= kind_d;
			ones_q   <= ones_d;
			cnt_q    <= cnt_d;
			pstart_q <= pstart_d;
			wpos_q   <= wpos_d;
		end
	end

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= isre_pkg::RUN_MAX)
		else $error("packet count beyond limit");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eol |=> (kind_q == isre_pkg::KIND_NONE) && (wpos_q == '0))
		else $error("line state not cleared after end of line");

	a_open_after: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !eol |=> (kind_q != isre_pkg::KIND_NONE) && (cnt_q != '0))
		else $error("no open packet after a mid-line byte");

endmodule

### rtl/core/isre_out_queue.sv
// ----------------------------------------------------------------------------
// isre_out_queue
// Holds one batch of writes and hands them out one word per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module isre_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  isre_pkg::batch_t    batch,
	output logic                can_load,
	isre_out_if.source          out_ch
);

	isre_pkg::wr_t [isre_pkg::MAX_WR-1:0] ent_q;
	logic [isre_pkg::CNT_W-1:0]           cnt_q;
	logic                                 pop;

	assign out_ch.valid       = (cnt_q != '0);
	assign out_ch.out_byte    = ent_q[0].data;
	assign out_ch.out_pos     = ent_q[0].pos;
	assign out_ch.line_done   = ent_q[0].done;
	assign out_ch.line_length = ent_q[0].len;

	assign pop      = out_ch.valid && out_ch.ready;
	assign can_load = (cnt_q == '0) || ((cnt_q == isre_pkg::CNT_W'(1)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= batch.wr;
		end else if (pop) begin
			for (int i = 0; i < isre_pkg::MAX_WR - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= isre_pkg::CNT_W'(isre_pkg::MAX_WR))
		else $error("queue count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("batch loaded over pending writes");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not follow a taken word");

endmodule

### rtl/core/img_scanline_run_encoder_unit.sv
// ----------------------------------------------------------------------------
// img_scanline_run_encoder_unit
// Run-length encoder for monochrome scanlines: solid runs and bit-string
// packets, emitted as byte writes into the encoded line buffer.
//
//   channel  dir  word
//   in_ch    in   in_byte, end_of_line
//   out_ch   out  out_byte, out_pos, line_done, line_length
//
// A byte is registered, encoded in the next cycle and its writes (zero to
// five) are handed out one per cycle from the output queue while out_ch is
// ready. Sustained rate is one byte per cycle while bytes give at most one
// write each and out_ch is ready; a byte with more writes keeps the queue
// busy until each is taken and holds the next writing byte meanwhile.
// Reset and end of line clear the packet state, so a new line starts from empty.
// Output stalls back up through the queue into the input register.
// ----------------------------------------------------------------------------
module img_scanline_run_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	isre_in_if.sink     in_ch,
	isre_out_if.source  out_ch
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eol_s1;
	logic             advance;
	logic             can_load;
	isre_pkg::batch_t batch;

	assign advance     = valid_s1 && ((batch.count == '0) || can_load);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			eol_s1  <= in_ch.end_of_line;
		end
	end

	isre_encoder u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data    (byte_s1),
		.eol     (eol_s1),
		.batch   (batch)
	);

	isre_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && (batch.count != '0)),
		.batch    (batch),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(eol_s1))
		else $error("held byte lost before encoding");

	a_eol_writes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eol_s1 |-> batch.count != '0)
		else $error("end of line without a closing write");

	a_mid_writes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !eol_s1 |-> batch.count <= isre_pkg::CNT_W'(3))
		else $error("too many writes for a mid-line byte");

endmodule
